FILE: src/qte_pkg.sv
// Shared constants, tables and types for the quaternion to Euler angle converter.
package qte_pkg;

  localparam int QUAT_FRAC_BITS  = 14;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 16;

  localparam int QW     = 16;                          // input component width
  localparam int PW     = 2 * QW;                      // product width
  localparam int NUM_W  = PW + 2;                      // matrix numerator width
  localparam int NQ_W   = PW + 1;                      // norm squared width
  localparam int QB     = QUAT_FRAC_BITS + 1;          // quotient bits
  localparam int DIV_W  = NUM_W - 1 + QUAT_FRAC_BITS + 1;
  localparam int MW     = QUAT_FRAC_BITS + 2;          // matrix entry width
  localparam int SQ_W   = 2 * QUAT_FRAC_BITS + 1;
  localparam int SUM_W  = SQ_W + 1;
  localparam int CY_W   = QUAT_FRAC_BITS + 1;

  localparam int CIN_W  = MW + 1;                      // CORDIC operand width
  localparam int PRESCL = 16;
  localparam int CX_W   = CIN_W + PRESCL + 3;
  localparam int ANG_W  = 35;
  localparam int AO_W   = 16;
  localparam int RND_SH = 30 - ANGLE_FRAC_BITS;
  localparam int RS_W   = ANG_W + 1 - RND_SH;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam longint PI_OUT_L = (64'sd3373259426 + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
  localparam logic signed [RS_W-1:0] PI_OUT = RS_W'(PI_OUT_L);

  localparam logic [29:0] ATAN_TAB [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149, 30'd1048576,
    30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768, 30'd16384, 30'd8192,
    30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128, 30'd64, 30'd32, 30'd16,
    30'd8, 30'd4, 30'd2, 30'd1, 30'd0
  };

  localparam int LAT_MAT    = 3 + QB + 1;
  localparam int LAT_SQRT   = 2 + CY_W;
  localparam int LAT_CORDIC = CORDIC_STAGES + 2;
  localparam int LAT_TOTAL  = LAT_MAT + LAT_SQRT + 1 + LAT_CORDIC;

  typedef struct packed {
    logic signed [MW-1:0] m00;
    logic signed [MW-1:0] m01;
    logic signed [MW-1:0] m02;
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
  } mat_t;

endpackage

FILE: src/qte_div.sv
// Pipelined restoring divider, one quotient bit per stage, sign applied at the end.
module qte_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [qte_pkg::DIV_W-1:0]        rem_i,
  input  logic [qte_pkg::NQ_W-1:0]         den_i,
  input  logic                             neg_i,
  output logic signed [qte_pkg::MW-1:0]    q_o
);

  logic [qte_pkg::DIV_W-1:0] rem_r [qte_pkg::QB];
  logic [qte_pkg::QB-1:0]    q_r   [qte_pkg::QB];
  logic [qte_pkg::NQ_W-1:0]  den_r [qte_pkg::QB];
  logic                      neg_r [qte_pkg::QB];

  for (genvar j = 0; j < qte_pkg::QB; j++) begin : g_stg
    localparam int K = qte_pkg::QB - 1 - j;
    logic [qte_pkg::DIV_W-1:0] rin, t, rem_nxt;
    logic [qte_pkg::QB-1:0]    qin, q_nxt;
    logic [qte_pkg::NQ_W-1:0]  din;
    logic                      nin, ge;
    if (j == 0) begin : g_first
      assign rin = rem_i;
      assign qin = '0;
      assign din = den_i;
      assign nin = neg_i;
    end else begin : g_next
      assign rin = rem_r[j-1];
      assign qin = q_r[j-1];
      assign din = den_r[j-1];
      assign nin = neg_r[j-1];
    end
    always_comb begin
      t       = qte_pkg::DIV_W'(din) << K;
      ge      = (rin >= t);
      rem_nxt = ge ? (rin - t) : rin;
      q_nxt   = qin;
      q_nxt[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        den_r[j] <= din;
        neg_r[j] <= nin;
      end
    end
  end

  logic signed [qte_pkg::MW-1:0] qs;
  assign qs  = $signed(qte_pkg::MW'(q_r[qte_pkg::QB-1]));
  assign q_o = neg_r[qte_pkg::QB-1] ? -qs : qs;

endmodule

FILE: src/qte_matrix.sv
// Rotation matrix entries: products, numerators, scaled division by the norm; identity for a zero norm.
module qte_matrix (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::QW-1:0] quat_x,
  input  logic signed [qte_pkg::QW-1:0] quat_y,
  input  logic signed [qte_pkg::QW-1:0] quat_z,
  input  logic signed [qte_pkg::QW-1:0] quat_w,
  output qte_pkg::mat_t                 mat_o
);

  localparam int NE = 7;

  logic signed [qte_pkg::PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      zz_r <= quat_z * quat_z;
      ww_r <= quat_w * quat_w;
      xy_r <= quat_x * quat_y;
      wz_r <= quat_w * quat_z;
      xz_r <= quat_x * quat_z;
      wy_r <= quat_w * quat_y;
      yz_r <= quat_y * quat_z;
      wx_r <= quat_w * quat_x;
    end
  end

  // numerators: m00 m01 m02 m11 m20 m21 m22
  logic signed [qte_pkg::NUM_W-1:0] n_nxt [NE];
  logic signed [qte_pkg::NUM_W-1:0] n_r   [NE];
  logic signed [qte_pkg::NUM_W-1:0] exx, eyy, ezz, eww;
  logic [qte_pkg::NQ_W-1:0]         nq_nxt, nq_r;

  always_comb begin
    exx = qte_pkg::NUM_W'(xx_r);
    eyy = qte_pkg::NUM_W'(yy_r);
    ezz = qte_pkg::NUM_W'(zz_r);
    eww = qte_pkg::NUM_W'(ww_r);
    n_nxt[0] = eww + exx - eyy - ezz;
    n_nxt[1] = (qte_pkg::NUM_W'(xy_r) - qte_pkg::NUM_W'(wz_r)) <<< 1;
    n_nxt[2] = (qte_pkg::NUM_W'(xz_r) + qte_pkg::NUM_W'(wy_r)) <<< 1;
    n_nxt[3] = eww + eyy - exx - ezz;
    n_nxt[4] = (qte_pkg::NUM_W'(xz_r) - qte_pkg::NUM_W'(wy_r)) <<< 1;
    n_nxt[5] = (qte_pkg::NUM_W'(yz_r) + qte_pkg::NUM_W'(wx_r)) <<< 1;
    n_nxt[6] = eww + ezz - exx - eyy;
    nq_nxt = qte_pkg::NQ_W'($unsigned(xx_r)) + qte_pkg::NQ_W'($unsigned(yy_r))
           + qte_pkg::NQ_W'($unsigned(zz_r)) + qte_pkg::NQ_W'($unsigned(ww_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= n_nxt;
      nq_r <= nq_nxt;
    end
  end

  // dividend = |num| * 2^frac + nq/2 for round half away from zero
  logic [qte_pkg::DIV_W-1:0] d_nxt [NE];
  logic [qte_pkg::DIV_W-1:0] d_r   [NE];
  logic [NE-1:0]             neg_nxt, neg_r;
  logic [qte_pkg::NUM_W-1:0] mag   [NE];
  logic [qte_pkg::NQ_W-1:0]  den_r;
  logic                      zq_r;

  always_comb begin
    for (int e = 0; e < NE; e++) begin
      neg_nxt[e] = n_r[e][qte_pkg::NUM_W-1];
      mag[e]     = neg_nxt[e] ? $unsigned(-n_r[e]) : $unsigned(n_r[e]);
      d_nxt[e]   = (qte_pkg::DIV_W'(mag[e]) << qte_pkg::QUAT_FRAC_BITS)
                 + qte_pkg::DIV_W'(nq_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      neg_r <= neg_nxt;
      den_r <= nq_r;
      zq_r  <= (nq_r == '0);
    end
  end

  logic signed [qte_pkg::MW-1:0] qd [NE];

  for (genvar e = 0; e < NE; e++) begin : g_div
    qte_div u_div (
      .clk   (clk),
      .en    (en),
      .rem_i (d_r[e]),
      .den_i (den_r),
      .neg_i (neg_r[e]),
      .q_o   (qd[e])
    );
  end

  logic zdly_r [qte_pkg::QB];

  always_ff @(posedge clk) begin
    if (en) begin
      zdly_r[0] <= zq_r;
      for (int i = 1; i < qte_pkg::QB; i++) zdly_r[i] <= zdly_r[i-1];
    end
  end

  localparam logic signed [qte_pkg::MW-1:0] ONE = qte_pkg::MW'(1 << qte_pkg::QUAT_FRAC_BITS);

  qte_pkg::mat_t mat_nxt, mat_r;

  always_comb begin
    if (zdly_r[qte_pkg::QB-1]) begin
      mat_nxt = '{m00: ONE, m01: '0, m02: '0, m11: ONE, m20: '0, m21: '0, m22: ONE};
    end else begin
      mat_nxt = '{m00: qd[0], m01: qd[1], m02: qd[2], m11: qd[3],
                  m20: qd[4], m21: qd[5], m22: qd[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) mat_r <= mat_nxt;
  end

  assign mat_o = mat_r;

endmodule

FILE: src/qte_sqrt.sv
// cy = floor(sqrt(m11^2 + m01^2)), one result bit per pipeline stage.
module qte_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::MW-1:0] m11_i,
  input  logic signed [qte_pkg::MW-1:0] m01_i,
  output logic [qte_pkg::CY_W-1:0]      cy_o
);

  logic signed [2*qte_pkg::MW-1:0] p11, p01;
  logic [qte_pkg::SQ_W-1:0]        s11_r, s01_r;
  logic [qte_pkg::SUM_W-1:0]       v0_r;

  assign p11 = m11_i * m11_i;
  assign p01 = m01_i * m01_i;

  always_ff @(posedge clk) begin
    if (en) begin
      s11_r <= qte_pkg::SQ_W'(p11);
      s01_r <= qte_pkg::SQ_W'(p01);
      v0_r  <= qte_pkg::SUM_W'(s11_r) + qte_pkg::SUM_W'(s01_r);
    end
  end

  logic [qte_pkg::SUM_W-1:0] v_r [qte_pkg::CY_W];
  logic [qte_pkg::SUM_W-1:0] r_r [qte_pkg::CY_W];

  for (genvar j = 0; j < qte_pkg::CY_W; j++) begin : g_stg
    localparam int K = qte_pkg::CY_W - 1 - j;
    localparam logic [qte_pkg::SUM_W-1:0] BIT = qte_pkg::SUM_W'(1) << (2 * K);
    logic [qte_pkg::SUM_W-1:0] vin, rin, v_nxt, r_nxt;
    logic [qte_pkg::SUM_W:0]   trial;
    logic                      ge;
    if (j == 0) begin : g_first
      assign vin = v0_r;
      assign rin = '0;
    end else begin : g_next
      assign vin = v_r[j-1];
      assign rin = r_r[j-1];
    end
    always_comb begin
      trial = (qte_pkg::SUM_W+1)'(rin) + (qte_pkg::SUM_W+1)'(BIT);
      ge    = ((qte_pkg::SUM_W+1)'(vin) >= trial);
      v_nxt = ge ? (vin - qte_pkg::SUM_W'(trial)) : vin;
      r_nxt = ge ? ((rin >> 1) + BIT) : (rin >> 1);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[j] <= v_nxt;
        r_r[j] <= r_nxt;
      end
    end
  end

  assign cy_o = r_r[qte_pkg::CY_W-1][qte_pkg::CY_W-1:0];

endmodule

FILE: src/qte_cordic.sv
// Pipelined vectoring CORDIC atan2, output negated and rounded to the angle format.
module qte_cordic (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qte_pkg::CIN_W-1:0] y_i,
  input  logic signed [qte_pkg::CIN_W-1:0] x_i,
  output logic signed [qte_pkg::AO_W-1:0]  ang_o
);

  localparam int NS = qte_pkg::CORDIC_STAGES + 1;

  logic signed [qte_pkg::CX_W-1:0]  x_r [NS];
  logic signed [qte_pkg::CX_W-1:0]  y_r [NS];
  logic signed [qte_pkg::ANG_W-1:0] a_r [NS];
  logic                             sp_r [NS];

  logic signed [qte_pkg::CX_W-1:0]  xs, ys, x0, y0;
  logic signed [qte_pkg::ANG_W-1:0] a0;
  logic                             sp0;

  always_comb begin
    xs  = qte_pkg::CX_W'(x_i) <<< qte_pkg::PRESCL;
    ys  = qte_pkg::CX_W'(y_i) <<< qte_pkg::PRESCL;
    sp0 = (y_i == '0) || (x_i == '0);
    x0  = xs;
    y0  = ys;
    a0  = '0;
    if (x_i < 0) begin
      if (y_i > 0) begin
        x0 = ys;
        y0 = -xs;
        a0 = qte_pkg::HALF_PI_Q30;
      end else begin
        x0 = -ys;
        y0 = xs;
        a0 = -qte_pkg::HALF_PI_Q30;
      end
    end
    priority if (y_i == '0) begin
      a0 = (x_i < 0) ? qte_pkg::PI_Q30 : '0;
    end else if (x_i == '0) begin
      a0 = (y_i > 0) ? qte_pkg::HALF_PI_Q30 : -qte_pkg::HALF_PI_Q30;
    end else begin
      a0 = a0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      a_r[0]  <= a0;
      sp_r[0] <= sp0;
    end
  end

  for (genvar i = 0; i < qte_pkg::CORDIC_STAGES; i++) begin : g_it
    localparam logic signed [qte_pkg::ANG_W-1:0] AT = qte_pkg::ANG_W'(qte_pkg::ATAN_TAB[i]);
    logic signed [qte_pkg::CX_W-1:0]  dx, dy, x_nxt, y_nxt;
    logic signed [qte_pkg::ANG_W-1:0] a_nxt;
    logic                             pos;
    always_comb begin
      dx  = y_r[i] >>> i;
      dy  = x_r[i] >>> i;
      pos = (y_r[i] > 0);
      if (pos) begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        a_nxt = a_r[i] + AT;
      end else begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        a_nxt = a_r[i] - AT;
      end
      if (sp_r[i]) a_nxt = a_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]  <= x_nxt;
        y_r[i+1]  <= y_nxt;
        a_r[i+1]  <= a_nxt;
        sp_r[i+1] <= sp_r[i];
      end
    end
  end

  logic signed [qte_pkg::ANG_W-1:0] ac;
  logic signed [qte_pkg::ANG_W:0]   rs;
  logic signed [qte_pkg::RS_W-1:0]  rq, rn, rc;
  logic signed [qte_pkg::AO_W-1:0]  ang_r;

  always_comb begin
    ac = a_r[NS-1];
    if (ac > qte_pkg::PI_Q30) ac = qte_pkg::PI_Q30;
    if (ac < -qte_pkg::PI_Q30) ac = -qte_pkg::PI_Q30;
    rs = (qte_pkg::ANG_W+1)'(ac) + ((qte_pkg::ANG_W+1)'(1) <<< (qte_pkg::RND_SH - 1));
    rq = qte_pkg::RS_W'(rs >>> qte_pkg::RND_SH);
    rn = -rq;
    rc = rn;
    if (rn > qte_pkg::PI_OUT) rc = qte_pkg::PI_OUT;
    if (rn < -qte_pkg::PI_OUT) rc = -qte_pkg::PI_OUT;
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= qte_pkg::AO_W'(rc);
  end

  assign ang_o = ang_r;

endmodule

FILE: src/quaternion_to_euler_angles_top.sv
// Path from input transfer to result: matrix, cy root, select register, CORDIC.
// Throughput: one transfer per cycle; every stage is registered and moves on a common enable.
// The enable drops only while a result sits in the output stage and is stalled.
// Reset (rst_n low, synchronous) clears all valid bits and the gimbal threshold.
// Quaternion to pitch/yaw/roll top level: matrix, cy root, branch select, three CORDICs.
module quaternion_to_euler_angles_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_x,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_y,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_z,
  input  logic signed [qte_pkg::QW-1:0]   in_quat_w,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [qte_pkg::AO_W-1:0] out_pitch_angle,
  output logic signed [qte_pkg::AO_W-1:0] out_yaw_angle,
  output logic signed [qte_pkg::AO_W-1:0] out_roll_angle,
  output logic                            out_gimbal_case,
  input  logic                            cfg_wr_en,
  input  logic [qte_pkg::CY_W-1:0]        cfg_wr_data
);

  logic adv;
  logic [qte_pkg::LAT_TOTAL-1:0] vld_r;
  logic [qte_pkg::CY_W-1:0]      thr_r;

  assign adv      = !vld_r[qte_pkg::LAT_TOTAL-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      thr_r <= '0;
    end else begin
      if (adv) vld_r <= {vld_r[qte_pkg::LAT_TOTAL-2:0], in_valid};
      if (cfg_wr_en) thr_r <= cfg_wr_data;
    end
  end

  qte_pkg::mat_t mat;

  qte_matrix u_mat (
    .clk    (clk),
    .en     (adv),
    .quat_x (in_quat_x),
    .quat_y (in_quat_y),
    .quat_z (in_quat_z),
    .quat_w (in_quat_w),
    .mat_o  (mat)
  );

  logic [qte_pkg::CY_W-1:0] cy;

  qte_sqrt u_sqrt (
    .clk   (clk),
    .en    (adv),
    .m11_i (mat.m11),
    .m01_i (mat.m01),
    .cy_o  (cy)
  );

  qte_pkg::mat_t mdly_r [qte_pkg::LAT_SQRT];

  always_ff @(posedge clk) begin
    if (adv) begin
      mdly_r[0] <= mat;
      for (int i = 1; i < qte_pkg::LAT_SQRT; i++) mdly_r[i] <= mdly_r[i-1];
    end
  end

  qte_pkg::mat_t md;
  logic signed [qte_pkg::CIN_W-1:0] py_r, px_r, yy_r, yx_r, ry_r, rx_r;
  logic gim_nxt, gim_r;

  assign md      = mdly_r[qte_pkg::LAT_SQRT-1];
  assign gim_nxt = !(cy > thr_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      py_r  <= -qte_pkg::CIN_W'(md.m21);
      px_r  <= $signed(qte_pkg::CIN_W'(cy));
      yy_r  <= gim_nxt ? -qte_pkg::CIN_W'(md.m02) : qte_pkg::CIN_W'(md.m20);
      yx_r  <= gim_nxt ? qte_pkg::CIN_W'(md.m00) : qte_pkg::CIN_W'(md.m22);
      ry_r  <= qte_pkg::CIN_W'(md.m01);
      rx_r  <= qte_pkg::CIN_W'(md.m11);
      gim_r <= gim_nxt;
    end
  end

  logic signed [qte_pkg::AO_W-1:0] pitch, yaw, roll;

  qte_cordic u_pitch (.clk(clk), .en(adv), .y_i(py_r), .x_i(px_r), .ang_o(pitch));
  qte_cordic u_yaw   (.clk(clk), .en(adv), .y_i(yy_r), .x_i(yx_r), .ang_o(yaw));
  qte_cordic u_roll  (.clk(clk), .en(adv), .y_i(ry_r), .x_i(rx_r), .ang_o(roll));

  logic gdly_r [qte_pkg::LAT_CORDIC];

  always_ff @(posedge clk) begin
    if (adv) begin
      gdly_r[0] <= gim_r;
      for (int i = 1; i < qte_pkg::LAT_CORDIC; i++) gdly_r[i] <= gdly_r[i-1];
    end
  end

  assign out_valid       = vld_r[qte_pkg::LAT_TOTAL-1];
  assign out_gimbal_case = gdly_r[qte_pkg::LAT_CORDIC-1];
  assign out_pitch_angle = pitch;
  assign out_yaw_angle   = yaw;
  assign out_roll_angle  = out_gimbal_case ? '0 : roll;

endmodule

FILE: src/qte_chk.sv
// Port-level checker for the converter top level, attached by bind.
module qte_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic signed [qte_pkg::QW-1:0]   in_quat_x,
  input logic signed [qte_pkg::QW-1:0]   in_quat_y,
  input logic signed [qte_pkg::QW-1:0]   in_quat_z,
  input logic signed [qte_pkg::QW-1:0]   in_quat_w,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [qte_pkg::AO_W-1:0] out_pitch_angle,
  input logic signed [qte_pkg::AO_W-1:0] out_yaw_angle,
  input logic signed [qte_pkg::AO_W-1:0] out_roll_angle,
  input logic                            out_gimbal_case
);

  localparam logic signed [qte_pkg::AO_W-1:0] PI_O = qte_pkg::AO_W'(qte_pkg::PI_OUT);

  a_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_angle) && $stable(out_yaw_angle)
      && $stable(out_roll_angle) && $stable(out_gimbal_case))
    else $error("stalled result transfer changed");

  a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_quat_x) && $stable(in_quat_y)
      && $stable(in_quat_z) && $stable(in_quat_w))
    else $error("stalled input transfer changed");

  a_bp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_roll0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_case |-> out_roll_angle == '0)
    else $error("roll not zero in gimbal case");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= PI_O && out_pitch_angle >= -PI_O
      && out_yaw_angle <= PI_O && out_yaw_angle >= -PI_O)
    else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles_top qte_chk u_qte_chk (.*);
